// File: src/ehft_pkg.sv
// ---------------------------------------------------------------------------
// Ethernet hash filter table package
// Operation codes, the item type and the constant hash masks. The hash of an
// address is an affine function of its bits, so each index bit is the parity
// of the address under a fixed mask, taken against the hash of address zero.
// ---------------------------------------------------------------------------
package ehft_pkg;

  localparam int MacWidth   = 48;
  localparam int TableWidth = 64;
  localparam int IndexWidth = 6;

  localparam logic [1:0] OpAdd   = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;

  typedef struct packed {
    logic [1:0]          op;
    logic [MacWidth-1:0] mac_address;
    logic [2:0]          byte_index;
    logic [7:0]          byte_value;
  } item_t;

  typedef logic [IndexWidth-1:0][MacWidth-1:0] mask_array_t;

  function automatic logic [IndexWidth-1:0] hash_ref(input logic [MacWidth-1:0] mac);
    logic [31:0]           crc;
    logic [IndexWidth-1:0] idx;
    crc = '1;
    for (int k = 0; k < MacWidth / 8; k++) begin
      crc = crc ^ {24'd0, mac[8*k +: 8]};
      for (int b = 0; b < 8; b++) begin
        if (crc[0]) begin
          crc = (crc >> 1) ^ CrcPoly;
        end else begin
          crc = crc >> 1;
        end
      end
    end
    for (int i = 0; i < IndexWidth; i++) begin
      idx[IndexWidth-1-i] = crc[3+i];
    end
    return idx;
  endfunction

  function automatic mask_array_t build_masks();
    mask_array_t           m;
    logic [IndexWidth-1:0] base;
    logic [IndexWidth-1:0] h;
    base = hash_ref('0);
    for (int i = 0; i < MacWidth; i++) begin
      h = hash_ref(MacWidth'(1) << i) ^ base;
      for (int j = 0; j < IndexWidth; j++) begin
        m[j][i] = h[j];
      end
    end
    return m;
  endfunction

  localparam logic [IndexWidth-1:0] HashBase  = hash_ref('0);
  localparam mask_array_t           HashMasks = build_masks();

endpackage

// File: src/ehft_hash.sv
// ---------------------------------------------------------------------------
// Ethernet hash filter table: address hash
// Six parity trees over the address give the table index of the CRC-32 hash.
// ---------------------------------------------------------------------------
module ehft_hash
  import ehft_pkg::*;
(
  input  logic [MacWidth-1:0]   mac_address,
  output logic [IndexWidth-1:0] hash
);

  always_comb begin
    for (int j = 0; j < IndexWidth; j++) begin
      hash[j] = HashBase[j] ^ (^(mac_address & HashMasks[j]));
    end
  end

endmodule

// File: src/ehft_table.sv
// ---------------------------------------------------------------------------
// Ethernet hash filter table: table state
// Holds the 64-bit table and works out its value after each word.
// ---------------------------------------------------------------------------
module ehft_table
  import ehft_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  update,
  input  item_t                 item,
  input  logic [IndexWidth-1:0] hash,
  output logic [TableWidth-1:0] table_next,
  output logic [IndexWidth-1:0] index_next
);

  logic [TableWidth-1:0] filter_table;

  always_comb begin
    table_next = filter_table;
    index_next = '0;
    unique case (item.op)
      OpAdd: begin
        table_next = filter_table | (TableWidth'(1) << hash);
        index_next = hash;
      end
      OpWrite: begin
        table_next[8*item.byte_index +: 8] = item.byte_value;
      end
      OpClear: begin
        table_next = '0;
      end
      default: begin
        table_next = filter_table;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_table <= '0;
    end else if (update) begin
      filter_table <= table_next;
    end
  end

endmodule

// File: src/ethernet_hash_filter_table.sv
// ---------------------------------------------------------------------------
// Ethernet hash filter table
// Keeps a 64-bit multicast hash filter table with add, write-byte and clear.
// ---------------------------------------------------------------------------
// The input channel carries one operation per word: op, mac_address,
// byte_index and byte_value. A word is taken at a clock edge where in_valid
// is high and in_stall is low. Each word yields exactly one output word with
// the whole table after the operation and the index set by an add, or zero.
// The word is registered on entry, the hash parity trees and the table update
// sit between that register and the output register, and out_valid rises when
// the word moves from the entry register into the output register. One word is
// taken every cycle while the receiver keeps out_stall low.
// When the receiver stalls with a result waiting, the word held in the entry
// register waits too, and in_stall rises only while both registers are full.
// The output word holds steady until it is taken.
// Synchronous reset empties both registers and clears the table to zero.
// ---------------------------------------------------------------------------
module ethernet_hash_filter_table
  import ehft_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            op,
  input  logic [MacWidth-1:0]   mac_address,
  input  logic [2:0]            byte_index,
  input  logic [7:0]            byte_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TableWidth-1:0] table_bits,
  output logic [IndexWidth-1:0] hash_index
);

  logic                  item_valid;
  item_t                 item;
  logic                  advance;
  logic [IndexWidth-1:0] hash;
  logic [TableWidth-1:0] table_next;
  logic [IndexWidth-1:0] index_next;

  assign advance  = item_valid & (~out_valid | ~out_stall);
  assign in_stall = item_valid & out_valid & out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.op          <= op;
      item.mac_address <= mac_address;
      item.byte_index  <= byte_index;
      item.byte_value  <= byte_value;
    end
  end

  ehft_hash u_hash (
    .mac_address (item.mac_address),
    .hash        (hash)
  );

  ehft_table u_table (
    .clk        (clk),
    .rst        (rst),
    .update     (advance),
    .item       (item),
    .hash       (hash),
    .table_next (table_next),
    .index_next (index_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      table_bits <= table_next;
      hash_index <= index_next;
    end
  end

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("Output register not empty after reset.");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> item_valid && out_valid && out_stall)
    else $error("Input stalled while a register was free.");

  a_index_bit_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && (hash_index != '0) |-> table_bits[hash_index])
    else $error("Reported hash index not set in the table.");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("Word moved on but no output word appeared.");

endmodule

// File: verif/tb_ethernet_hash_filter_table.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Ethernet hash filter table testbench
// A short table of directed operations, followed by about 950 random ones.
// Each is sent over the valid/stall input channel with random gaps while the
// receiver stalls at random. Every output word is compared, field by field,
// with the table state and hash index kept by an independent bit-serial
// CRC-32 predictor of the filter, or with the table that a directed row gives.
// ---------------------------------------------------------------------------
module tb_ethernet_hash_filter_table;
  import ehft_pkg::*;

  localparam logic [1:0] OpUnused    = 2'd3;
  localparam int         NumDirected = 26;
  localparam int         NumRandom   = 950;
  localparam int         IdleLimit   = 500;
  localparam int         DrainCycles = 8;

  typedef struct packed {
    logic [1:0]            op;
    logic [MacWidth-1:0]   mac;
    logic [2:0]            bidx;
    logic [7:0]            bval;
    logic                  known;
    logic [TableWidth-1:0] tbl;
  } stim_row_t;

  typedef struct packed {
    logic [TableWidth-1:0] tbl;
    logic [IndexWidth-1:0] hidx;
  } snapshot_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            op;
  logic [MacWidth-1:0]   mac_address;
  logic [2:0]            byte_index;
  logic [7:0]            byte_value;
  logic                  out_valid;
  logic                  out_stall;
  logic [TableWidth-1:0] table_bits;
  logic [IndexWidth-1:0] hash_index;

  logic [TableWidth-1:0] filter_model;
  snapshot_t             pending_snapshots[$];
  logic [MacWidth-1:0]   last_mac;
  bit                    no_idle;
  int                    error_count;
  int                    words_sent;
  int                    words_checked;
  int                    op_counts[4];
  int                    idle_cycles;

  ethernet_hash_filter_table u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .mac_address (mac_address),
    .byte_index  (byte_index),
    .byte_value  (byte_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .table_bits  (table_bits),
    .hash_index  (hash_index)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [IndexWidth-1:0] hash_of_address(input logic [MacWidth-1:0] mac);
    logic [31:0]           crc;
    logic                  fb;
    logic [IndexWidth-1:0] idx;
    crc = 32'hFFFF_FFFF;
    for (int i = 0; i < MacWidth; i++) begin
      fb  = crc[0] ^ mac[i];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ CrcPoly;
      end
    end
    for (int i = 0; i < IndexWidth; i++) begin
      idx[IndexWidth-1-i] = crc[3+i];
    end
    return idx;
  endfunction

  task automatic apply_operation(input stim_row_t w, output snapshot_t s);
    s.hidx = '0;
    case (w.op)
      OpAdd: begin
        s.hidx       = hash_of_address(w.mac);
        filter_model = filter_model | (TableWidth'(1) << s.hidx);
      end
      OpWrite: begin
        filter_model[8*w.bidx +: 8] = w.bval;
      end
      OpClear: begin
        filter_model = '0;
      end
      default: begin
      end
    endcase
    s.tbl = filter_model;
  endtask

  function automatic stim_row_t row(input logic [1:0] o, input logic [MacWidth-1:0] m,
                                    input logic [2:0] bi, input logic [7:0] bv,
                                    input logic k, input logic [TableWidth-1:0] t);
    stim_row_t r;
    r.op    = o;
    r.mac   = m;
    r.bidx  = bi;
    r.bval  = bv;
    r.known = k;
    r.tbl   = t;
    return r;
  endfunction

  function automatic stim_row_t directed_row(input int n);
    stim_row_t r;
    r = '0;
    case (n)
      0:  r = row(OpUnused, 48'h0, 3'd0, 8'h00, 1'b1, 64'h0);
      1:  r = row(OpAdd, 48'h0, 3'd0, 8'h00, 1'b0, 64'h0);
      2:  r = row(OpClear, 48'h0, 3'd0, 8'h00, 1'b1, 64'h0);
      3:  r = row(OpAdd, 48'hFFFF_FFFF_FFFF, 3'd7, 8'hFF, 1'b0, 64'h0);
      4:  r = row(OpAdd, 48'hFFFF_FFFF_FFFF, 3'd0, 8'h00, 1'b0, 64'h0);
      5:  r = row(OpUnused, 48'h1234_5678_9ABC, 3'd5, 8'h5A, 1'b0, 64'h0);
      6:  r = row(OpClear, 48'hFFFF_FFFF_FFFF, 3'd7, 8'hFF, 1'b1, 64'h0);
      7:  r = row(OpUnused, 48'hFFFF_FFFF_FFFF, 3'd7, 8'hFF, 1'b1, 64'h0);
      8:  r = row(OpWrite, 48'h0, 3'd0, 8'hFF, 1'b1, 64'h0000_0000_0000_00FF);
      9:  r = row(OpWrite, 48'h0, 3'd7, 8'h80, 1'b1, 64'h8000_0000_0000_00FF);
      10: r = row(OpWrite, 48'h0, 3'd7, 8'h00, 1'b1, 64'h0000_0000_0000_00FF);
      11: r = row(OpWrite, 48'h0, 3'd0, 8'h01, 1'b1, 64'h0000_0000_0000_0001);
      12: r = row(OpWrite, 48'h0, 3'd1, 8'hFF, 1'b1, 64'h0000_0000_0000_FF01);
      13: r = row(OpWrite, 48'h0, 3'd0, 8'hFF, 1'b1, 64'h0000_0000_0000_FFFF);
      14: r = row(OpWrite, 48'h0, 3'd2, 8'hFF, 1'b1, 64'h0000_0000_00FF_FFFF);
      15: r = row(OpWrite, 48'h0, 3'd3, 8'hFF, 1'b1, 64'h0000_0000_FFFF_FFFF);
      16: r = row(OpWrite, 48'h0, 3'd4, 8'hFF, 1'b1, 64'h0000_00FF_FFFF_FFFF);
      17: r = row(OpWrite, 48'h0, 3'd5, 8'hFF, 1'b1, 64'h0000_FFFF_FFFF_FFFF);
      18: r = row(OpWrite, 48'h0, 3'd6, 8'hFF, 1'b1, 64'h00FF_FFFF_FFFF_FFFF);
      19: r = row(OpWrite, 48'h0, 3'd7, 8'hFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
      20: r = row(OpAdd, 48'h0000_0000_0001, 3'd0, 8'h00, 1'b0, 64'h0);
      21: r = row(OpWrite, 48'h0, 3'd4, 8'h00, 1'b1, 64'hFFFF_FF00_FFFF_FFFF);
      22: r = row(OpAdd, 48'h0100_005E_0001, 3'd0, 8'h00, 1'b0, 64'h0);
      23: r = row(OpAdd, 48'h5555_5555_5555, 3'd2, 8'h55, 1'b0, 64'h0);
      24: r = row(OpAdd, 48'hAAAA_AAAA_AAAA, 3'd5, 8'hAA, 1'b0, 64'h0);
      default: r = row(OpClear, 48'hFFFF_FFFF_FFFF, 3'd0, 8'h00, 1'b1, 64'h0);
    endcase
    return r;
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t r;
    int        pick;
    r      = '0;
    pick   = $urandom_range(99);
    r.op   = (pick < 62) ? OpAdd : (pick < 82) ? OpWrite : (pick < 90) ? OpClear : OpUnused;
    pick   = $urandom_range(9);
    if (pick < 6) begin
      r.mac = MacWidth'({$urandom, $urandom});
    end else if (pick < 7) begin
      r.mac    = MacWidth'({$urandom, $urandom});
      r.mac[0] = 1'b1;
    end else if (pick < 8) begin
      r.mac = MacWidth'(1) << $urandom_range(MacWidth - 1);
    end else if (pick < 9) begin
      r.mac = last_mac;
    end else begin
      r.mac = ~(MacWidth'(1) << $urandom_range(MacWidth - 1));
    end
    r.bidx = 3'($urandom_range(7));
    pick   = $urandom_range(9);
    r.bval = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
    return r;
  endfunction

  task automatic send_word(input stim_row_t w);
    int        gap;
    snapshot_t s;
    gap = no_idle ? 0 : $urandom_range(9);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid    = 1'b1;
    op          = w.op;
    mac_address = w.mac;
    byte_index  = w.bidx;
    byte_value  = w.bval;
    do begin
      @(posedge clk);
    end while (in_stall);
    apply_operation(w, s);
    if (w.known) begin
      s.tbl  = w.tbl;
      s.hidx = '0;
    end
    pending_snapshots.push_back(s);
    last_mac = w.mac;
    words_sent++;
    op_counts[w.op]++;
  endtask

  task automatic report_mismatch(input string what, input logic [TableWidth-1:0] got,
                                 input logic [TableWidth-1:0] want);
    $display("MISMATCH at %0t: %s, got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      int wait_cycles;
      wait_cycles = no_idle ? 0 : $urandom_range(9);
      repeat (wait_cycles) begin
        @(negedge clk);
        out_stall = 1'b1;
      end
      @(negedge clk);
      out_stall = 1'b0;
      do begin
        @(posedge clk);
      end while (!out_valid || rst);
    end
  end

  always @(posedge clk) begin
    snapshot_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_snapshots.size() == 0) begin
        report_mismatch("output word with nothing pending", table_bits, '0);
      end else begin
        want = pending_snapshots.pop_front();
        words_checked++;
        if (table_bits !== want.tbl) begin
          report_mismatch("table_bits", table_bits, want.tbl);
        end
        if (hash_index !== want.hidx) begin
          report_mismatch("hash_index", TableWidth'(hash_index), TableWidth'(want.hidx));
        end
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Timed out after %0d cycles with no word moving, %0d outstanding",
                 idle_cycles, pending_snapshots.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    op           = OpAdd;
    mac_address  = '0;
    byte_index   = '0;
    byte_value   = '0;
    filter_model = '0;
    last_mac     = '0;
    no_idle      = 1'b0;
    error_count  = 0;
    words_sent   = 0;
    words_checked = 0;
    for (int i = 0; i < 4; i++) begin
      op_counts[i] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int n = 0; n < NumDirected; n++) begin
      send_word(directed_row(n));
    end

    for (int n = 0; n < NumRandom; n++) begin
      if (n % 64 == 0) begin
        no_idle = ($urandom_range(3) == 0);
      end
      send_word(random_row());
    end
    @(negedge clk);
    in_valid = 1'b0;
    no_idle  = 1'b0;

    while (pending_snapshots.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d words: %0d adds, %0d byte writes, %0d clears, %0d unused codes.",
             words_sent, op_counts[OpAdd], op_counts[OpWrite], op_counts[OpClear],
             op_counts[OpUnused]);
    $display("Checked %0d output words, %0d mismatches.", words_checked, error_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/ehft_pkg.sv
src/ehft_hash.sv
src/ehft_table.sv
src/ethernet_hash_filter_table.sv
verif/tb_ethernet_hash_filter_table.sv
